FILE: rtl/hms_countdown_timer_with_key_setting_macros.svh
// assertion macros shared by the checker of the countdown timer
// no dependencies; included by files that hold concurrent assertions
`ifndef HMS_COUNTDOWN_TIMER_WITH_KEY_SETTING_MACROS_SVH
`define HMS_COUNTDOWN_TIMER_WITH_KEY_SETTING_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define HMS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication of a consequent in the same cycle
`define HMS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// implication of a consequent in the following cycle
`define HMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hms_cdt_pkg.sv
// shared types and constants of the hours/minutes/seconds countdown timer
// no dependencies; used by the top level and its checker
package hms_cdt_pkg;

  localparam int unsigned KeyW     = 4;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned TotalW   = 17;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  localparam logic [HourW-1:0]  HourMax     = HourW'(23);
  localparam logic [MinW-1:0]   MinMax      = MinW'(59);
  localparam logic [SecW-1:0]   SecMax      = SecW'(59);
  localparam logic [TotalW-1:0] SecsPerHour = TotalW'(3600);
  localparam logic [TotalW-1:0] SecsPerMin  = TotalW'(60);

  // output tdata layout, lowest bit first
  localparam int unsigned AlarmLsb = 0;
  localparam int unsigned HourLsb  = 1;
  localparam int unsigned MinLsb   = HourLsb + HourW;
  localparam int unsigned SecLsb   = MinLsb + MinW;
  localparam int unsigned TotalLsb = SecLsb + SecW;
  localparam int unsigned PadLsb   = TotalLsb + TotalW;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_KEY  = 1'b1
  } kind_e;

  typedef enum logic [KeyW-1:0] {
    KEY_NONE   = 4'd0,
    KEY_START  = 4'd1,
    KEY_DELETE = 4'd2,
    KEY_INC_H  = 4'd3,
    KEY_INC_M  = 4'd4,
    KEY_INC_S  = 4'd5,
    KEY_DEC_H  = 4'd6,
    KEY_DEC_M  = 4'd7,
    KEY_DEC_S  = 4'd8
  } key_code_e;

  // total in seconds of a time value
  function automatic logic [TotalW-1:0] to_seconds(input logic [HourW-1:0] h,
                                                    input logic [MinW-1:0]  m,
                                                    input logic [SecW-1:0]  s);
    return TotalW'(TotalW'(h) * SecsPerHour) + TotalW'(TotalW'(m) * SecsPerMin)
           + TotalW'(s);
  endfunction

endpackage

FILE: rtl/hms_countdown_timer_with_key_setting.sv
// top level of the hours/minutes/seconds countdown timer with key setting
// depends on hms_cdt_pkg
//
// The timer holds hours (0-23), minutes and seconds. A tick transfer (tuser 0)
// counts down one second, borrowing from minutes and then hours; a tick that
// finds the value at zero while armed disarms the timer and flags alarm on that
// result only. A key transfer (tuser 1) is ignored when its code equals the last
// accepted key; otherwise the code is recorded, the timer arms, and the key
// clears all (delete), or steps hours, minutes or seconds up or down with
// wraparound; other codes only record and arm. Every input transfer gives
// exactly one result carrying alarm, the three fields and the total in seconds.
// One item is accepted per clock cycle; it passes the input register and then the
// result register, and the sustained rate follows only the downstream tready.
module hms_countdown_timer_with_key_setting
  import hms_cdt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic                s_axis_tuser,   // kind
  input  logic [InDataW-1:0]  s_axis_tdata,   // key_code[3:0], zero pad
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // alarm, hours, minutes, seconds,
                                              // total_seconds, zero pad
);

  // pipeline control
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic advance;   // result register free or being drained
  logic in_load;   // input transfer this cycle
  logic step;      // stage-one item moves into the result register

  // input register payload
  logic            kind_q;
  logic [KeyW-1:0] key_q;

  // timer state, which doubles as the result payload
  logic [HourW-1:0]  hour_q, hour_d;
  logic [MinW-1:0]   min_q, min_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic              armed_q, armed_d;
  logic [KeyW-1:0]   prev_key_q, prev_key_d;
  logic              alarm_q, alarm_d;
  logic [TotalW-1:0] total_q, total_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;
  assign step          = in_valid_q && advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      kind_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[KeyW-1:0];
    end
  end

  // one step of the timer: countdown on tick, setting on a new key
  always_comb begin
    hour_d     = hour_q;
    min_d      = min_q;
    sec_d      = sec_q;
    armed_d    = armed_q;
    prev_key_d = prev_key_q;
    alarm_d    = 1'b0;

    if (kind_q == KIND_TICK) begin
      priority if (sec_q != '0) begin
        sec_d = sec_q - SecW'(1);
      end else if (min_q != '0) begin
        min_d = min_q - MinW'(1);
        sec_d = SecMax;
      end else if (hour_q != '0) begin
        hour_d = hour_q - HourW'(1);
        min_d  = MinMax;
        sec_d  = SecMax;
      end else if (armed_q) begin
        // armed and already at zero
        armed_d = 1'b0;
        alarm_d = 1'b1;
      end else begin
        // at zero and not armed: nothing changes
      end
    end else if (key_q != prev_key_q) begin
      prev_key_d = key_q;
      armed_d    = 1'b1;
      unique case (key_q)
        KEY_DELETE: begin
          hour_d = '0;
          min_d  = '0;
          sec_d  = '0;
        end
        KEY_INC_H: hour_d = (hour_q >= HourMax) ? '0 : hour_q + HourW'(1);
        KEY_INC_M: min_d  = (min_q >= MinMax)   ? '0 : min_q + MinW'(1);
        KEY_INC_S: sec_d  = (sec_q >= SecMax)   ? '0 : sec_q + SecW'(1);
        KEY_DEC_H: hour_d = (hour_q == '0) ? HourMax : hour_q - HourW'(1);
        KEY_DEC_M: min_d  = (min_q == '0)  ? MinMax  : min_q - MinW'(1);
        KEY_DEC_S: sec_d  = (sec_q == '0)  ? SecMax  : sec_q - SecW'(1);
        default: begin
          // none, start and unassigned codes only record and arm
        end
      endcase
    end

    total_d = to_seconds(hour_d, min_d, sec_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q     <= '0;
      min_q      <= '0;
      sec_q      <= '0;
      armed_q    <= 1'b0;
      prev_key_q <= KEY_NONE;
    end else if (step) begin
      hour_q     <= hour_d;
      min_q      <= min_d;
      sec_q      <= sec_d;
      armed_q    <= armed_d;
      prev_key_q <= prev_key_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      alarm_q <= alarm_d;
      total_q <= total_d;
    end
  end

  // result transfer
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW-PadLsb)'(0), total_q, sec_q, min_q, hour_q, alarm_q};

endmodule

FILE: rtl/hms_cdt_checker.sv
// port-level checker of the countdown timer, bound to the top level
// depends on hms_cdt_pkg and the assertion macro header
`include "hms_countdown_timer_with_key_setting_macros.svh"

module hms_cdt_checker
  import hms_cdt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic              alarm;
  logic [HourW-1:0]  hours;
  logic [MinW-1:0]   minutes;
  logic [SecW-1:0]   seconds;
  logic [TotalW-1:0] total;

  assign alarm   = m_axis_tdata[AlarmLsb];
  assign hours   = m_axis_tdata[HourLsb +: HourW];
  assign minutes = m_axis_tdata[MinLsb +: MinW];
  assign seconds = m_axis_tdata[SecLsb +: SecW];
  assign total   = m_axis_tdata[TotalLsb +: TotalW];

  // a stalled result holds
  `HMS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  // fields stay in range
  `HMS_ASSERT_IMPL(a_range, clk_i, rst_ni, m_axis_tvalid, hours <= HourMax && minutes <= MinMax && seconds <= SecMax, "time field out of range")
  // total agrees with the fields
  `HMS_ASSERT_IMPL(a_total, clk_i, rst_ni, m_axis_tvalid, total == to_seconds(hours, minutes, seconds), "total does not match fields")
  // alarm only with the countdown at zero
  `HMS_ASSERT_IMPL(a_alarm_zero, clk_i, rst_ni, m_axis_tvalid && alarm, total == '0, "alarm with nonzero time")

endmodule

bind hms_countdown_timer_with_key_setting hms_cdt_checker u_hms_cdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
